// ===== rtl/rc4_bitkey_stream_cipher_top_assert.svh =====
// assertion macros shared by the rc4 bit-key cipher rtl
// expects signals clk and rst_n in the scope of every use
`ifndef RC4_BITKEY_STREAM_CIPHER_TOP_ASSERT_SVH
`define RC4_BITKEY_STREAM_CIPHER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RC4BK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RC4BK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RC4BK_ASSERT_IMP(lbl, ante, cons, msg)
`define RC4BK_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/rc4bk_pkg.sv =====
// shared types and constants for the rc4 bit-key cipher
// no dependencies
package rc4bk_pkg;

    localparam int PERM_DEPTH = 256;
    localparam int IDX_W      = $clog2(PERM_DEPTH);
    localparam int KEY_W      = 64;
    localparam int KEY_IDX_W  = $clog2(KEY_W);
    localparam int BYTE_W     = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K_RDI,
        ST_K_RDJ,
        ST_K_WRI,
        ST_K_WRJ,
        ST_D_RDI,
        ST_D_RDJ,
        ST_D_WRI,
        ST_D_WRJ
    } state_t;

    typedef enum logic [1:0] {
        RD_I,
        RD_J,
        RD_R
    } rd_sel_t;

    typedef struct packed {
        logic    clr_tab;   // back to identity, i and j to zero
        logic    load_data; // i += 1, capture data byte
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    take_si;   // capture s[i], update j
        logic    add_kbit;  // key bit joins the j update
        logic    take_sj;   // capture s[j], write s[i]
        logic    wr_j;      // write s[j]
        logic    step_i;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic i_last;
    } dp_sts_t;

endpackage

// ===== rtl/rc4_bitkey_stream_cipher_top.sv =====
// top level of the rc4-style cipher with bit-wise key schedule
// depends on rc4bk_pkg, rc4bk_ctrl and rc4bk_dp
//
// Byte stream cipher in the rc4 style. A transaction with cmd = 0 rekeys:
// the 256-entry permutation goes back to identity, i and j to zero, and 256
// swap rounds run in which j += s[i] + bit (i mod 64) of the key register.
// j is kept afterwards and carries into keystream generation. A transaction
// with cmd = 1 steps the generator and returns data_byte xor the keystream
// byte on out_byte; the same operation encrypts and decrypts. The key
// register is loaded on the cfg channel (cfg_ready is always high) and is
// read one bit per round for the whole schedule; write it while the block
// is idle.
// Sequencing: the permutation lives in a single-port-read, single-port-write
// memory, and each swap needs two reads and two writes through it, so a
// keystream byte steps through ST_D_RDI, ST_D_RDJ, ST_D_WRI and ST_D_WRJ before
// it reaches the result register, and the block takes no new transaction
// until it is back in idle. A rekey holds in_stall through all 256 rounds
// of ST_K_RDI, ST_K_RDJ, ST_K_WRI and ST_K_WRJ.
// Identity reset costs no clearing pass: one valid bit per entry is cleared
// at once by reset or rekey. in_stall is high whenever a transaction is in
// progress; a finished result waits in the output register while the next
// transaction is accepted, and the last step of a keystream transaction
// holds only while that register is still occupied and out_stall is high.

module rc4_bitkey_stream_cipher_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [rc4bk_pkg::BYTE_W-1:0]      data_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rc4bk_pkg::BYTE_W-1:0]      out_byte,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rc4bk_pkg::KEY_W-1:0]       cfg_data
);
    import rc4bk_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;
    logic    cfg_we;

    // key writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    rc4bk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd),
        .sts       (dp_sts)
    );

    rc4bk_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .data_byte (data_byte),
        .cmd       (dp_cmd),
        .sts       (dp_sts),
        .out_byte  (out_byte)
    );

endmodule

// ===== rtl/rc4bk_dp.sv =====
// datapath: permutation memory with valid bits, indices, key and output byte
// depends on rc4bk_pkg and rc4_bitkey_stream_cipher_top_assert.svh
`include "rc4_bitkey_stream_cipher_top_assert.svh"

module rc4bk_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rc4bk_pkg::KEY_W-1:0]       cfg_data,
    input  logic [rc4bk_pkg::BYTE_W-1:0]      data_byte,
    input  rc4bk_pkg::dp_cmd_t                cmd,
    output rc4bk_pkg::dp_sts_t                sts,
    output logic [rc4bk_pkg::BYTE_W-1:0]      out_byte
);
    import rc4bk_pkg::*;

    logic [BYTE_W-1:0]     tab_mem [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] valid_reg;

    logic [KEY_W-1:0]  key_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [BYTE_W-1:0] si_reg;
    logic [BYTE_W-1:0] sj_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_addr_reg;

    logic [BYTE_W-1:0] rd_eff;
    logic              kbit;
    logic [IDX_W-1:0]  j_next;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] ks_byte;

    // entries never written since the last rekey read as identity
    assign rd_eff = rd_valid_reg ? rd_data_reg : rd_addr_reg;
    assign kbit   = cmd.add_kbit & key_reg[i_reg[KEY_IDX_W-1:0]];
    assign j_next = j_reg + rd_eff + {{(IDX_W-1){1'b0}}, kbit};

    always_comb
    begin
        case (cmd.rd_sel)
            RD_I:    rd_addr = i_reg;
            RD_J:    rd_addr = j_next;
            RD_R:    rd_addr = si_reg + rd_eff;
            default: rd_addr = i_reg;
        endcase
    end

    assign wr_en   = cmd.take_sj | cmd.wr_j;
    assign wr_addr = cmd.take_sj ? i_reg : j_reg;
    assign wr_data = cmd.take_sj ? rd_eff : si_reg;

    // s[r] as it stands after the swap
    always_comb
    begin
        if (rd_addr_reg == i_reg)
            ks_byte = sj_reg;
        else if (rd_addr_reg == j_reg)
            ks_byte = si_reg;
        else
            ks_byte = rd_eff;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tab_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
        begin
            rd_data_reg <= tab_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_tab)
                valid_reg <= '0;
            else if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (cmd.rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            i_reg   <= '0;
            j_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                key_reg <= cfg_data;
            if (cmd.clr_tab)
                i_reg <= '0;
            else if (cmd.load_data || cmd.step_i)
                i_reg <= i_reg + 1'b1;
            if (cmd.clr_tab)
                j_reg <= '0;
            else if (cmd.take_si)
                j_reg <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_data)
            data_reg <= data_byte;
        if (cmd.take_si)
            si_reg <= rd_eff;
        if (cmd.take_sj)
            sj_reg <= rd_eff;
        if (cmd.out_load)
            out_byte_reg <= data_reg ^ ks_byte;
    end

    assign sts.i_last = (i_reg == IDX_W'(PERM_DEPTH - 1));
    assign out_byte   = out_byte_reg;

    `RC4BK_ASSERT_IMP(a_one_write, cmd.take_sj, !cmd.wr_j && !cmd.clr_tab, "two writes in one cycle")
    `RC4BK_ASSERT_NXT(a_clr_idx, cmd.clr_tab, i_reg == '0 && j_reg == '0 && valid_reg == '0, "rekey init failed")

endmodule

// ===== rtl/rc4bk_ctrl.sv =====
// controller: sequences rekey rounds and keystream steps, owns output valid
// depends on rc4bk_pkg and rc4_bitkey_stream_cipher_top_assert.svh
`include "rc4_bitkey_stream_cipher_top_assert.svh"

module rc4bk_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                cmd,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output rc4bk_pkg::dp_cmd_t  dp_cmd,
    input  rc4bk_pkg::dp_sts_t  sts
);
    import rc4bk_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        dp_cmd        = '0;
        dp_cmd.rd_sel = RD_I;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd)
                    begin
                        dp_cmd.load_data = 1'b1;
                        state_next       = ST_D_RDI;
                    end
                    else
                    begin
                        dp_cmd.clr_tab = 1'b1;
                        state_next     = ST_K_RDI;
                    end
                end
            end
            ST_K_RDI:
            begin
                dp_cmd.rd_en = 1'b1;
                state_next   = ST_K_RDJ;
            end
            ST_K_RDJ:
            begin
                dp_cmd.take_si  = 1'b1;
                dp_cmd.add_kbit = 1'b1;
                dp_cmd.rd_en    = 1'b1;
                dp_cmd.rd_sel   = RD_J;
                state_next      = ST_K_WRI;
            end
            ST_K_WRI:
            begin
                dp_cmd.take_sj = 1'b1;
                state_next     = ST_K_WRJ;
            end
            ST_K_WRJ:
            begin
                dp_cmd.wr_j   = 1'b1;
                dp_cmd.step_i = 1'b1;
                state_next    = sts.i_last ? ST_IDLE : ST_K_RDI;
            end
            ST_D_RDI:
            begin
                dp_cmd.rd_en = 1'b1;
                state_next   = ST_D_RDJ;
            end
            ST_D_RDJ:
            begin
                dp_cmd.take_si = 1'b1;
                dp_cmd.rd_en   = 1'b1;
                dp_cmd.rd_sel  = RD_J;
                state_next     = ST_D_WRI;
            end
            ST_D_WRI:
            begin
                dp_cmd.take_sj = 1'b1;
                dp_cmd.rd_en   = 1'b1;
                dp_cmd.rd_sel  = RD_R;
                state_next     = ST_D_WRJ;
            end
            ST_D_WRJ:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    dp_cmd.wr_j     = 1'b1;
                    dp_cmd.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (dp_cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    `RC4BK_ASSERT_NXT(a_data_start, state_reg == ST_IDLE && in_valid && cmd, state_reg == ST_D_RDI, "data transaction not started")
    `RC4BK_ASSERT_IMP(a_out_origin, $rose(out_valid_reg), $past(state_reg) == ST_D_WRJ, "result without keystream step")
    `RC4BK_ASSERT_NXT(a_sched_end, state_reg == ST_K_WRJ && sts.i_last, state_reg == ST_IDLE, "schedule overran 256 rounds")

endmodule
